// ----- rtl/ktsamp_pkg.sv -----
// Keyframe track sampler: shared types, codes and a saturating arithmetic helper.
// No dependencies; imported by the front end, back end and top level of the sampler.
`default_nettype none
package ktsamp_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int QDEPTH         = 2;
  localparam int FRAME_W        = 128;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  localparam logic REG_INTERP_MODE = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  localparam logic [1:0] INTERP_MODE_RST = MODE_LINEAR;
  localparam logic [6:0] FRAME_COUNT_RST = 7'd0;

  typedef struct packed {
    logic               command;
    logic [5:0]         key_index;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] in_slope;
    logic signed [31:0] out_slope;
    logic signed [31:0] sample_time;
    logic               looping;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ktsamp_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ktsamp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/ktsamp_front.sv -----
// Front end: takes commands, drops writes beyond the store, queues the rest.
// Depends on ktsamp_pkg.
`default_nettype none
module ktsamp_front #(
  parameter int MAX_FRAMES = ktsamp_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire ktsamp_pkg::item_t   item_i,
  output ktsamp_pkg::item_t        q_item_o,
  output logic                     q_valid_o,
  input  wire logic                q_ready_i
);
  import ktsamp_pkg::*;

  localparam int QCW = $clog2(QDEPTH + 1);
  localparam int QPW = $clog2(QDEPTH);

  item_t          entry_q [QDEPTH];
  logic [QCW-1:0] count_q, count_d;
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic           keep, push, pop;

  assign busy_o    = (count_q == QCW'(QDEPTH));
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = entry_q[rd_ptr_q];

  assign keep = (item_i.command == CMD_SAMPLE) ||
                ({26'd0, item_i.key_index} < 32'(MAX_FRAMES));
  assign push = start_i && !busy_o && keep;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + QCW'(1);
    else if (pop && !push) count_d = count_q - QCW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ktsamp_back.sv -----
// Back end: executes queued writes and samples over the keyframe RAM,
// with a shared shift-subtract divider and one shared multiplier.
// Depends on ktsamp_pkg and ktsamp_ram.
`default_nettype none
module ktsamp_back #(
  parameter int MAX_FRAMES = ktsamp_pkg::MAX_FRAMES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ktsamp_pkg::item_t  item_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire logic [1:0]         interp_mode_i,
  input  wire logic [6:0]         frame_count_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      sample_value_o,
  output logic                    status_o
);
  import ktsamp_pkg::*;

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int NW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_START, S_RD_END, S_RD_PEN, S_MOD, S_SRCH,
    S_SEL, S_F0, S_F1, S_DIV, S_MUL
  } state_e;

  state_e state_q;

  logic                ram_we;
  logic [IW-1:0]       ram_addr;
  logic [FRAME_W-1:0]  ram_wdata, ram_rdata;
  logic signed [31:0]  rd_time, rd_value, rd_in, rd_out;

  logic [NW-1:0]       n_cur, n_q, nm1, nm2;
  logic [IW-1:0]       idx_q;
  logic                loop_q, neg_q;
  logic signed [32:0]  tm_q;
  logic signed [31:0]  start_q, end_q;
  logic signed [31:0]  t0_q, v0_q, os0_q, v1_q, is1_q, s1_q, s2_q;
  logic signed [32:0]  gap_q;
  logic [16:0]         t_q, tt_q, ttt_q;
  logic [3:0]          step_q;
  logic signed [55:0]  acc_q;
  logic                res_valid_q, res_status_q;
  logic signed [31:0]  res_value_q;

  // divider
  logic [33:0]         rem_q, rem_sh, rem_nx;
  logic [32:0]         dvd_q, div_d_q;
  logic [15:0]         q_q, q_nx;
  logic [5:0]          cnt_q;
  logic                div_ge;
  logic [32:0]         mod_r;

  // multiplier
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_d, prod_q, rnd_p;
  logic signed [55:0]  acc_sum, rnd_acc;

  logic signed [32:0]  start_x, end_x, span, x_off, rd_time_x;
  logic signed [32:0]  tt_time, gap, u_off;
  logic signed [19:0]  t20, tt20, ttt20, h1, h2, h3, h4;

  assign rd_time  = ram_rdata[127:96];
  assign rd_value = ram_rdata[95:64];
  assign rd_in    = ram_rdata[63:32];
  assign rd_out   = ram_rdata[31:0];

  assign n_cur = ({25'd0, frame_count_i} > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES)
                                                              : NW'(frame_count_i);
  assign nm1 = n_q - NW'(1);
  assign nm2 = n_q - NW'(2);

  ktsamp_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_FRAMES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign item_ready_o = (state_q == S_IDLE);
  assign ram_wdata = {item_i.key_time, item_i.key_value, item_i.in_slope, item_i.out_slope};

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_q;
    case (state_q)
      S_IDLE: begin
        ram_we   = item_valid_i && (item_i.command == CMD_WRITE);
        ram_addr = (item_i.command == CMD_WRITE) ? IW'(item_i.key_index) : '0;
      end
      S_RD_START: ram_addr = nm1[IW-1:0];
      S_RD_END:   ram_addr = nm2[IW-1:0];
      S_RD_PEN:   ram_addr = nm1[IW-1:0];
      S_MOD:      ram_addr = nm1[IW-1:0];
      S_SRCH:     ram_addr = idx_q - IW'(1);
      S_SEL:      ram_addr = idx_q;
      S_F0:       ram_addr = idx_q + IW'(1);
      default:    ram_addr = idx_q;
    endcase
  end

  // Shift-subtract step, shared by the wrap remainder and the blend factor.
  assign rem_sh = {rem_q[32:0], dvd_q[32]};
  assign div_ge = (rem_sh >= {1'b0, div_d_q});
  assign rem_nx = div_ge ? rem_sh - {1'b0, div_d_q} : rem_sh;
  assign q_nx   = {q_q[14:0], div_ge};
  assign mod_r  = (neg_q && rem_nx != '0) ? div_d_q - rem_nx[32:0] : rem_nx[32:0];

  assign start_x   = {start_q[31], start_q};
  assign end_x     = {end_q[31], end_q};
  assign span      = end_x - start_x;
  assign x_off     = tm_q - start_x;
  assign rd_time_x = {rd_time[31], rd_time};

  always_comb begin
    tt_time = tm_q;
    if (!loop_q) begin
      if (tt_time <= start_x) tt_time = start_x;
      if (tt_time >= end_x) tt_time = end_x;
    end
  end
  assign gap   = rd_time_x - {t0_q[31], t0_q};
  assign u_off = tt_time - {t0_q[31], t0_q};

  // Hermite basis
  assign t20   = signed'({3'd0, t_q});
  assign tt20  = signed'({3'd0, tt_q});
  assign ttt20 = signed'({3'd0, ttt_q});
  assign h1 = (ttt20 <<< 1) - (tt20 + (tt20 <<< 1)) + 20'sd65536;
  assign h2 = (tt20 + (tt20 <<< 1)) - (ttt20 <<< 1);
  assign h3 = ttt20 - (tt20 <<< 1) + t20;
  assign h4 = ttt20 - tt20;

  always_comb begin
    mul_a = {v1_q[31], v1_q} - {v0_q[31], v0_q};
    mul_b = signed'({16'd0, t_q});
    if (interp_mode_i == MODE_CUBIC) begin
      case (step_q)
        4'd0: begin mul_a = signed'({16'd0, t_q}); mul_b = signed'({16'd0, t_q}); end
        4'd1: begin mul_a = {os0_q[31], os0_q};    mul_b = gap_q; end
        4'd2: begin mul_a = signed'({16'd0, tt_q}); mul_b = signed'({16'd0, t_q}); end
        4'd3: begin mul_a = {is1_q[31], is1_q};    mul_b = gap_q; end
        4'd4: begin mul_a = {v0_q[31], v0_q};      mul_b = 33'(h1); end
        4'd5: begin mul_a = {v1_q[31], v1_q};      mul_b = 33'(h2); end
        4'd6: begin mul_a = {s1_q[31], s1_q};      mul_b = 33'(h3); end
        default: begin mul_a = {s2_q[31], s2_q};   mul_b = 33'(h4); end
      endcase
    end
  end

  assign prod_d  = mul_a * mul_b;
  assign rnd_p   = (prod_q + 66'sd32768) >>> 16;
  assign acc_sum = acc_q + prod_q[55:0];
  assign rnd_acc = (acc_sum + 56'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_valid_q  <= 1'b0;
      res_status_q <= 1'b0;
      res_value_q  <= '0;
      n_q <= '0; idx_q <= '0; loop_q <= 1'b0; neg_q <= 1'b0; tm_q <= '0;
      start_q <= '0; end_q <= '0; t0_q <= '0; v0_q <= '0; os0_q <= '0;
      v1_q <= '0; is1_q <= '0; s1_q <= '0; s2_q <= '0; gap_q <= '0;
      t_q <= '0; tt_q <= '0; ttt_q <= '0; step_q <= '0; acc_q <= '0;
      rem_q <= '0; dvd_q <= '0; div_d_q <= '0; q_q <= '0; cnt_q <= '0;
      prod_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      prod_q      <= prod_d;
      case (state_q)
        S_IDLE: begin
          if (item_valid_i && item_i.command == CMD_SAMPLE) begin
            tm_q   <= {item_i.sample_time[31], item_i.sample_time};
            loop_q <= item_i.looping;
            n_q    <= n_cur;
            if (n_cur < NW'(2)) begin
              res_valid_q  <= 1'b1;
              res_value_q  <= '0;
              res_status_q <= 1'b1;
            end else begin
              state_q <= S_RD_START;
            end
          end
        end
        S_RD_START: begin
          start_q <= rd_time;
          state_q <= S_RD_END;
        end
        S_RD_END: begin
          end_q   <= rd_time;
          state_q <= S_RD_PEN;
        end
        S_RD_PEN: begin
          idx_q <= nm1[IW-1:0];
          if (span <= 33'sd0 && (loop_q || interp_mode_i != MODE_CONST)) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= '0;
            res_status_q <= 1'b1;
            state_q      <= S_IDLE;
          end else if (loop_q) begin
            neg_q   <= x_off[32];
            dvd_q   <= x_off[32] ? 33'(-x_off) : 33'(x_off);
            div_d_q <= span;
            rem_q   <= '0;
            cnt_q   <= 6'd33;
            state_q <= S_MOD;
          end else if (tm_q < start_x) begin
            idx_q   <= '0;
            state_q <= S_SEL;
          end else if (tm_q > rd_time_x) begin
            idx_q   <= nm2[IW-1:0];
            state_q <= S_SEL;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_MOD: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[31:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            tm_q    <= start_x + signed'({1'b0, mod_r[31:0]});
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (tm_q >= rd_time_x) begin
            state_q <= S_SEL;
          end else if (idx_q == '0) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= '0;
            res_status_q <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            idx_q <= idx_q - IW'(1);
          end
        end
        S_SEL: state_q <= S_F0;
        S_F0: begin
          t0_q  <= rd_time;
          v0_q  <= rd_value;
          os0_q <= rd_out;
          if (interp_mode_i == MODE_CONST) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= rd_value;
            res_status_q <= 1'b0;
            state_q      <= S_IDLE;
          end else if (NW'(idx_q) >= nm1) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= '0;
            res_status_q <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_F1;
          end
        end
        S_F1: begin
          v1_q   <= rd_value;
          is1_q  <= rd_in;
          gap_q  <= gap;
          step_q <= '0;
          if (gap <= 33'sd0) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= '0;
            res_status_q <= 1'b1;
            state_q      <= S_IDLE;
          end else if (u_off <= 33'sd0) begin
            t_q     <= '0;
            state_q <= S_MUL;
          end else if (u_off >= gap) begin
            t_q     <= 17'd65536;
            state_q <= S_MUL;
          end else begin
            rem_q   <= {1'b0, u_off};
            dvd_q   <= '0;
            div_d_q <= gap;
            cnt_q   <= 6'd16;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[31:0], 1'b0};
          q_q   <= q_nx;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            t_q     <= {1'b0, q_nx};
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          step_q <= step_q + 4'd1;
          if (interp_mode_i != MODE_CUBIC) begin
            if (step_q == 4'd1) begin
              res_valid_q  <= 1'b1;
              res_value_q  <= sat32(64'({{32{v0_q[31]}}, v0_q}) + rnd_p[63:0]);
              res_status_q <= 1'b0;
              state_q      <= S_IDLE;
            end
          end else begin
            case (step_q)
              4'd1: tt_q  <= rnd_p[16:0];
              4'd2: s1_q  <= sat32(rnd_p[63:0]);
              4'd3: ttt_q <= rnd_p[16:0];
              4'd4: s2_q  <= sat32(rnd_p[63:0]);
              4'd5: acc_q <= prod_q[55:0];
              4'd6, 4'd7: acc_q <= acc_sum;
              4'd8: begin
                res_valid_q  <= 1'b1;
                res_value_q  <= sat32({{8{rnd_acc[55]}}, rnd_acc});
                res_status_q <= 1'b0;
                state_q      <= S_IDLE;
              end
              default: ;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign sample_value_o = res_value_q;
  assign status_o       = res_status_q;

`ifndef SYNTHESIS
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> state_q == S_IDLE) else $error("result strobe outside idle");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE) else $error("frame write outside idle");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD || state_q == S_DIV) |-> rem_q < {1'b0, div_d_q})
    else $error("divider remainder out of range");
  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> NW'(idx_q) < n_q) else $error("search index beyond frames");
`endif

endmodule
`default_nettype wire

// ----- rtl/keyframe_track_sampler_core.sv -----
// Keyframe track sampler top level: APB registers, command queue, executor.
// Depends on ktsamp_pkg, ktsamp_front, ktsamp_back.
//
//  channel  | handshake            | payload
//  command  | start / busy         | command, key_index, key_time, key_value,
//           |                      | in_slope, out_slope, sample_time, looping
//  result   | result_valid_o       | sample_value_o, status_o
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// A write is done in the executor's idle state; a sample on a short track is
// answered from idle, and at most reads the end frame times, takes the wrap
// remainder, searches backward over N frames (one RAM read each), divides for
// the blend factor and runs the cubic multiply sequence; the single-port frame
// RAM and the one shared divider/multiplier keep these steps sequential. A
// two-entry queue lets commands arrive while the executor works; busy is high
// only while it is full. Reset clears control; the frame RAM is not cleared.
// The receiver cannot stall: each result is shown for one cycle.
`default_nettype none
module keyframe_track_sampler_core #(
  parameter int MAX_FRAMES = ktsamp_pkg::MAX_FRAMES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic [5:0]         key_index_i,
  input  wire logic signed [31:0] key_time_i,
  input  wire logic signed [31:0] key_value_i,
  input  wire logic signed [31:0] in_slope_i,
  input  wire logic signed [31:0] out_slope_i,
  input  wire logic signed [31:0] sample_time_i,
  input  wire logic               looping_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      sample_value_o,
  output logic                    status_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ktsamp_pkg::*;

  logic [1:0] interp_mode_q;
  logic [6:0] frame_count_q;
  logic       cfg_wr;
  item_t      in_item, q_item;
  logic       q_valid, q_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_mode_q <= INTERP_MODE_RST;
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_INTERP_MODE) interp_mode_q <= pwdata[1:0];
      else frame_count_q <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? {25'd0, frame_count_q}
                                                : {30'd0, interp_mode_q};

  assign in_item = '{command: command_i, key_index: key_index_i, key_time: key_time_i,
                     key_value: key_value_i, in_slope: in_slope_i,
                     out_slope: out_slope_i, sample_time: sample_time_i,
                     looping: looping_i};

  ktsamp_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .item_i    (in_item),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready)
  );

  ktsamp_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (q_item),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .interp_mode_i  (interp_mode_q),
    .frame_count_i  (frame_count_q),
    .result_valid_o (result_valid_o),
    .sample_value_o (sample_value_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for keyframe_track_sampler_core: directed table then random traffic.
// Depends on ktsamp_pkg and the sampler RTL; a built-in predictor checks the untyped samples.
`timescale 1ns / 100ps
module tb_top;
  import ktsamp_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_INVALID = 1'b1;
  localparam logic [2:0] ADDR_MODE = {REG_INTERP_MODE, 2'b00};
  localparam logic [2:0] ADDR_COUNT = {REG_FRAME_COUNT, 2'b00};
  localparam int SLOTS = 64;
  localparam int SETTLE_CYC = 150;
  localparam int STALL_LIMIT = 3000;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [5:0]         slot;
    logic signed [31:0] ktime, kvalue, kin, kout, stime;
    logic               loop;
    bit                 typed;
    logic signed [31:0] exp_value;
    logic               exp_status;
    logic [2:0]         addr;
    logic [31:0]        data;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } sample_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic command_i = CMD_WRITE;
  logic [5:0] key_index_i = '0;
  logic signed [31:0] key_time_i = '0, key_value_i = '0, in_slope_i = '0, out_slope_i = '0;
  logic signed [31:0] sample_time_i = '0;
  logic looping_i = 1'b0;
  logic result_valid_o;
  logic signed [31:0] sample_value_o;
  logic status_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  keyframe_track_sampler_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_index_i, .key_time_i, .key_value_i,
    .in_slope_i, .out_slope_i, .sample_time_i, .looping_i, .result_valid_o,
    .sample_value_o, .status_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the track and the registers
  longint key_t[SLOTS], key_v[SLOTS], key_in[SLOTS], key_out[SLOTS];
  logic [1:0] mode_q = INTERP_MODE_RST;
  logic [6:0] count_q = FRAME_COUNT_RST;

  sample_result_t pending_results[$];
  stim_row_t directed_rows[$];
  int errors = 0, n_writes = 0, n_samples = 0, n_results = 0, n_invalid = 0;
  int idle_pct = 0;
  int stall_cnt = 0;

  function automatic longint rnd16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic sample_result_t sample_track(input longint tm, input logic loop);
    sample_result_t res;
    int n, idx, i;
    longint t0, t_end, span, r, tcl, gap, u, t, tq, tc, h1, h2, h3, h4, s1, s2, acc;
    res.value = '0;
    res.status = STAT_INVALID;
    n = (count_q > SLOTS) ? SLOTS : int'(count_q);
    if (n < 2) return res;
    t0 = key_t[0];
    t_end = key_t[n-1];
    span = t_end - t0;
    if (span <= 0 && (loop || mode_q != MODE_CONST)) return res;
    idx = -1;
    if (loop) begin
      r = (tm - t0) % span;
      if (r < 0) r += span;
      tm = r + t0;
    end else if (tm < key_t[0]) begin
      idx = 0;
    end else if (tm > key_t[n-2]) begin
      idx = n - 2;
    end
    if (idx < 0) begin
      for (i = n - 1; i >= 0; i--) begin
        if (tm >= key_t[i]) begin
          idx = i;
          break;
        end
      end
      if (idx < 0) return res;
    end
    if (mode_q == MODE_CONST) begin
      res.value = key_v[idx][31:0];
      res.status = STAT_OK;
      return res;
    end
    if (idx >= n - 1) return res;
    tcl = tm;
    if (!loop) begin
      if (tcl <= t0) tcl = t0;
      if (tcl >= t_end) tcl = t_end;
    end
    gap = key_t[idx+1] - key_t[idx];
    if (gap <= 0) return res;
    u = tcl - key_t[idx];
    if (u <= 0) t = 0;
    else if (u >= gap) t = 65536;
    else t = (u * 65536) / gap;
    if (mode_q == MODE_CUBIC) begin
      tq = rnd16(t * t);
      tc = rnd16(tq * t);
      h1 = 2 * tc - 3 * tq + 65536;
      h2 = -2 * tc + 3 * tq;
      h3 = tc - 2 * tq + t;
      h4 = tc - tq;
      s1 = longint'(clip32(rnd16(key_out[idx] * gap)));
      s2 = longint'(clip32(rnd16(key_in[idx+1] * gap)));
      acc = key_v[idx] * h1 + key_v[idx+1] * h2 + s1 * h3 + s2 * h4;
      res.value = clip32(rnd16(acc));
    end else begin
      res.value = clip32(key_v[idx] + rnd16((key_v[idx+1] - key_v[idx]) * t));
    end
    res.status = STAT_OK;
    return res;
  endfunction

  // results cannot be held off: take each one at the edge that ends its cycle
  always @(posedge clk_i) begin
    sample_result_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h status=%b", $time, sample_value_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (sample_value_o !== want.value || status_o !== want.status) begin
          errors++;
          $display("%0t: mismatch expected value=%h status=%b actual value=%h status=%b",
                   $time, want.value, want.status, sample_value_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [5:0] slot,
                           input logic signed [31:0] kt, kv, kin, kout, stime,
                           input logic loop, input bit typed,
                           input logic signed [31:0] ev, input logic es);
    sample_result_t want;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(20, 1)) @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    key_index_i <= slot;
    key_time_i <= kt;
    key_value_i <= kv;
    in_slope_i <= kin;
    out_slope_i <= kout;
    sample_time_i <= stime;
    looping_i <= loop;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (cmd == CMD_WRITE) begin
      n_writes++;
      key_t[slot] = kt;
      key_v[slot] = kv;
      key_in[slot] = kin;
      key_out[slot] = kout;
    end else begin
      n_samples++;
      want = sample_track(longint'(stime), loop);
      if (typed) begin
        want.value = ev;
        want.status = es;
      end
      if (want.status == STAT_INVALID) n_invalid++;
      pending_results.push_back(want);
    end
  endtask

  // hold stimulus until every outstanding sample has come back, then let writes settle
  task automatic drain;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (addr == ADDR_MODE) mode_q = data[1:0];
    else count_q = data[6:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [5:0] slot,
                         input logic signed [31:0] a, b, c, d,
                         input logic loop, input bit typed,
                         input logic signed [31:0] ev, input logic es);
    stim_row_t row;
    row.kind = kind;
    row.slot = slot;
    row.ktime = a;
    row.kvalue = b;
    row.kin = c;
    row.kout = d;
    row.stime = a;
    row.loop = loop;
    row.typed = typed;
    row.exp_value = ev;
    row.exp_status = es;
    row.addr = slot[2:0];
    row.data = b;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] rand_word;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h60000)) - 32'sh30000;
    endcase
  endfunction

  // lay down a well-formed track of increasing times over every slot
  task automatic fill_track(input int max_gap);
    logic signed [31:0] tm;
    tm = $signed($urandom_range(32'h40000)) - 32'sh20000;
    for (int i = 0; i < SLOTS; i++) begin
      send_item(CMD_WRITE, i[5:0], tm, rand_word(), rand_word(), rand_word(), '0,
                1'b0, 1'b0, '0, STAT_OK);
      tm = tm + $urandom_range(max_gap, 1);
    end
  endtask

  task automatic random_phase(input int items, input int max_gap);
    int n;
    longint lo, w, pick;
    logic [5:0] slot;
    logic signed [31:0] tm;
    fill_track(max_gap);
    for (int k = 0; k < items; k++) begin
      if (k % 90 == 0) begin
        reg_write(ADDR_MODE, $urandom_range(3));
        case ($urandom_range(4))
          0: reg_write(ADDR_COUNT, 2);
          1: reg_write(ADDR_COUNT, SLOTS);
          2: reg_write(ADDR_COUNT, 127);
          default: reg_write(ADDR_COUNT, $urandom_range(SLOTS));
        endcase
      end
      if (k == items / 2) drain();
      n = (count_q > SLOTS) ? SLOTS : int'(count_q);
      if ($urandom_range(99) < 20) begin
        slot = $urandom;
        tm = key_t[slot][31:0];
        if ($urandom_range(9) == 0) tm = $urandom;
        send_item(CMD_WRITE, slot, tm, rand_word(), rand_word(), rand_word(), '0,
                  1'b0, 1'b0, '0, STAT_OK);
      end else begin
        lo = key_t[0];
        w = (n >= 2) ? key_t[n-1] - lo : 0;
        if (w <= 0) w = 32'h10000;
        pick = lo - w / 4 + longint'({$urandom, $urandom} % (w * 3 / 2 + 1));
        tm = ($urandom_range(9) == 0) ? $signed($urandom) : clip32(pick);
        send_item(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom, tm,
                  $urandom_range(1), 1'b0, '0, STAT_OK);
      end
    end
  endtask

  initial begin
    stim_row_t row;
    // short tracks, clamping and wrapping extremes, every mode, bad gap, empty span
    add_row(ROW_CFG, ADDR_COUNT, '0, 0, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 0, '0, '0, '0, 0, 1, '0, STAT_INVALID);
    add_row(ROW_WRITE, 0, 0, 32'h10000, 0, 0, 0, 0, '0, STAT_OK);
    add_row(ROW_WRITE, 1, 32'h10000, 32'h30000, 32'sh7fffffff, 32'sh80000000, 0, 0, '0, STAT_OK);
    add_row(ROW_WRITE, 2, 32'h20000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, '0,
            STAT_OK);
    add_row(ROW_WRITE, 3, 32'h30000, 32'sh80000000, 0, 0, 0, 0, '0, STAT_OK);
    add_row(ROW_CFG, ADDR_COUNT, '0, 1, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h8000, '0, '0, '0, 1, 1, '0, STAT_INVALID);
    add_row(ROW_CFG, ADDR_COUNT, '0, 2, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h8000, '0, '0, '0, 0, 1, 32'h20000, STAT_OK);
    add_row(ROW_CFG, ADDR_COUNT, '0, 4, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh80000000, '0, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh7fffffff, '0, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh7fffffff, '0, '0, '0, 1, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh80000000, '0, '0, '0, 1, 0, '0, STAT_OK);
    add_row(ROW_CFG, ADDR_MODE, '0, MODE_CONST, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh80000000, '0, '0, '0, 0, 1, 32'h10000, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'sh7fffffff, '0, '0, '0, 0, 1, 32'sh7fffffff, STAT_OK);
    add_row(ROW_CFG, ADDR_MODE, '0, MODE_CUBIC, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h8000, '0, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h28000, '0, '0, '0, 1, 0, '0, STAT_OK);
    add_row(ROW_CFG, ADDR_MODE, '0, MODE_SPARE, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h18000, '0, '0, '0, 0, 0, '0, STAT_OK);
    add_row(ROW_WRITE, 63, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0,
            '0, STAT_OK);
    // last frame falls back before the one it follows
    add_row(ROW_WRITE, 3, 32'h18000, 32'h5000, 0, 0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h38000, '0, '0, '0, 0, 1, '0, STAT_INVALID);
    add_row(ROW_WRITE, 3, 0, 32'h5000, 0, 0, 0, 0, '0, STAT_OK);
    add_row(ROW_SAMPLE, '0, 32'h8000, '0, '0, '0, 1, 1, '0, STAT_INVALID);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 10;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG: reg_write(row.addr, row.data);
        ROW_WRITE: send_item(CMD_WRITE, row.slot, row.ktime, row.kvalue, row.kin, row.kout,
                             '0, 1'b0, 1'b0, '0, STAT_OK);
        default: send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, row.stime, row.loop, row.typed,
                           row.exp_value, row.exp_status);
      endcase
    end

    random_phase(300, 32'h20000);
    idle_pct = 78;
    random_phase(300, 32'h400000);
    idle_pct = 0;
    random_phase(300, 32'h800);

    drain();
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Covered %0d keyframe writes and %0d samples (%0d invalid) in all modes,",
             n_writes, n_samples, n_invalid);
    $display("clamped and looped, under three sender idle profiles; %0d results seen.",
             n_results);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- keyframe_track_sampler_core.f -----
rtl/ktsamp_pkg.sv
rtl/ktsamp_ram.sv
rtl/ktsamp_front.sv
rtl/ktsamp_back.sv
rtl/keyframe_track_sampler_core.sv
tb/tb_top.sv
